[src/lphr_pkg.sv]
package lphr_pkg;

	localparam int RING_BYTES = 128;
	localparam int LINE_BYTES = 64;
	localparam int PW = $clog2(RING_BYTES);
	localparam int GW = $clog2(RING_BYTES + 1);

	localparam logic [1:0] REQ_SAVE   = 2'd0;
	localparam logic [1:0] REQ_OLDER  = 2'd1;
	localparam logic [1:0] REQ_NEWER  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] ST_BYTE     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_REJECT   = 3'd2;
	localparam logic [2:0] ST_NO_OLDER = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_SV_HD  = 14'b00000000000100,
		S_SV_EV  = 14'b00000000001000,
		S_SV_EV2 = 14'b00000000010000,
		S_SV_WR  = 14'b00000000100000,
		S_CNT    = 14'b00000001000000,
		S_CNT2   = 14'b00000010000000,
		S_FND    = 14'b00000100000000,
		S_FND2   = 14'b00001000000000,
		S_EMH    = 14'b00010000000000,
		S_EMB    = 14'b00100000000000,
		S_EMB2   = 14'b01000000000000,
		S_SV_FIN = 14'b10000000000000
	} state_t;

endpackage

[src/length_prefixed_history_ring.sv]
// save: each save byte keeps busy until it is written; the final byte then writes the end marker and strobes done
// the first save byte first evicts the oldest records until there is room; a bad length is strobed the next cycle
// recall: the record headers are walked twice, to count and then to find the record, then each byte is emitted
// one item at a time: busy is high from accept until the item is done; a save byte that is not the last gives no result
// reset: ring cleared by a pass over all RING_BYTES bytes after arst_n, busy held high meanwhile
// results are strobed for one cycle each; the receiver cannot stall
module length_prefixed_history_ring (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [6:0] line_len,
	input  logic [7:0] data_byte,
	output logic       strobe,
	output logic [2:0] status,
	output logic [7:0] out_byte,
	output logic [6:0] record_len,
	output logic       last
);
	localparam int PW = lphr_pkg::PW;
	localparam int GW = lphr_pkg::GW;

	logic [7:0] mem [lphr_pkg::RING_BYTES];
	logic [7:0] rdata_q;
	logic [PW-1:0] raddr, waddr;
	logic [7:0] wdata;
	logic rd_en, wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	lphr_pkg::state_t state_q;
	logic [PW-1:0] oldest_q, wpos_q, h_q;
	logic [6:0] depth_q, cnt_q, j_q, save_q, len_q, k_q;
	logic [7:0] byte_q;
	logic [GW-1:0] guard_q;
	logic older_q;

	function automatic logic [PW-1:0] wrp(input logic [PW+8:0] x);
		return PW'(x % lphr_pkg::RING_BYTES);
	endfunction

	// has_room with header value of oldest
	function automatic logic room(input logic [PW-1:0] b, input logic [PW-1:0] e,
			input logic [7:0] hb, input logic [6:0] n);
		logic signed [10:0] r;
		if (hb == 8'd0) return 1'b1;
		if (e >= b) r = 11'(lphr_pkg::RING_BYTES) - 11'(e) + 11'(b) - 11'sd1;
		else r = 11'(b) - 11'(e) - 11'sd1;
		return r > $signed(11'(n));
	endfunction

	always_comb begin
		rd_en = 1'b0; raddr = h_q; wr_en = 1'b0; waddr = h_q; wdata = 8'd0;
		unique case (state_q)
			lphr_pkg::S_CLEAR: begin wr_en = 1'b1; waddr = h_q; end
			lphr_pkg::S_SV_HD: begin rd_en = 1'b1; raddr = wpos_q; end
			lphr_pkg::S_SV_EV: begin rd_en = 1'b1; raddr = oldest_q; end
			lphr_pkg::S_SV_WR: begin
				wr_en = 1'b1; waddr = wrp((PW+9)'(wpos_q) + (PW+9)'(1) + save_q);
				wdata = byte_q;
			end
			lphr_pkg::S_SV_FIN: begin wr_en = 1'b1; waddr = wpos_q; end
			lphr_pkg::S_CNT, lphr_pkg::S_FND, lphr_pkg::S_EMH: begin
				rd_en = 1'b1; raddr = h_q;
			end
			lphr_pkg::S_EMB: begin
				rd_en = 1'b1; raddr = wrp((PW+9)'(h_q) + (PW+9)'(1) + k_q);
			end
			default: ;
		endcase
		// header writes and abandon
		if (state_q == lphr_pkg::S_SV_EV2 && save_q == 7'd0 &&
				(room(oldest_q, wpos_q, rdata_q, len_q) ||
				32'(guard_q) >= lphr_pkg::RING_BYTES)) begin
			wr_en = 1'b1; waddr = wpos_q; wdata = 8'(len_q);
		end
		if (state_q == lphr_pkg::S_IDLE && start && req_type != lphr_pkg::REQ_SAVE
				&& req_type != lphr_pkg::REQ_UNUSED && save_q != 7'd0) begin
			wr_en = 1'b1; waddr = wpos_q;
		end
	end

	assign busy = (state_q != lphr_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphr_pkg::S_CLEAR; oldest_q <= '0; wpos_q <= '0; h_q <= '0;
			depth_q <= '0; save_q <= '0; strobe <= 1'b0; guard_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				lphr_pkg::S_CLEAR: begin
					h_q <= h_q + 1'b1;
					if (h_q == PW'(lphr_pkg::RING_BYTES - 1)) state_q <= lphr_pkg::S_IDLE;
				end
				lphr_pkg::S_IDLE: if (start) begin
					byte_q <= data_byte;
					if (req_type == lphr_pkg::REQ_SAVE) begin
						if (save_q == 7'd0) begin
							if (line_len == 7'd0 || 32'(line_len) > lphr_pkg::RING_BYTES - 2
									|| 32'(line_len) > lphr_pkg::LINE_BYTES) begin
								strobe <= 1'b1; status <= lphr_pkg::ST_REJECT; last <= 1'b1;
								out_byte <= '0; record_len <= '0;
							end else begin
								len_q <= line_len; guard_q <= '0;
								state_q <= lphr_pkg::S_SV_EV;
							end
						end else state_q <= lphr_pkg::S_SV_HD;
					end else if (req_type != lphr_pkg::REQ_UNUSED) begin
						save_q <= '0; older_q <= (req_type == lphr_pkg::REQ_OLDER);
						h_q <= oldest_q; cnt_q <= '0; guard_q <= '0;
						state_q <= lphr_pkg::S_CNT;
					end
				end
				lphr_pkg::S_SV_HD: state_q <= lphr_pkg::S_SV_EV2;
				lphr_pkg::S_SV_EV: state_q <= lphr_pkg::S_SV_EV2;
				lphr_pkg::S_SV_EV2: begin
					if (save_q != 7'd0) begin
						if (rdata_q == 8'd0) begin
							save_q <= '0; strobe <= 1'b1; status <= lphr_pkg::ST_REJECT;
							last <= 1'b1; out_byte <= '0; record_len <= '0;
							state_q <= lphr_pkg::S_IDLE;
						end else begin
							len_q <= rdata_q[6:0]; state_q <= lphr_pkg::S_SV_WR;
						end
					end else if (room(oldest_q, wpos_q, rdata_q, len_q)
							|| 32'(guard_q) >= lphr_pkg::RING_BYTES) begin
						state_q <= lphr_pkg::S_SV_WR;
					end else begin
						oldest_q <= wrp((PW+9)'(oldest_q) + rdata_q + (PW+9)'(1));
						guard_q <= guard_q + 1'b1; state_q <= lphr_pkg::S_SV_EV;
					end
				end
				lphr_pkg::S_SV_WR: begin
					save_q <= save_q + 1'b1;
					if (save_q + 1'b1 >= len_q) begin
						wpos_q <= wrp((PW+9)'(wpos_q) + len_q + (PW+9)'(1));
						state_q <= lphr_pkg::S_SV_FIN;
					end else state_q <= lphr_pkg::S_IDLE;
				end
				lphr_pkg::S_SV_FIN: begin
					depth_q <= '0; save_q <= '0; strobe <= 1'b1; status <= lphr_pkg::ST_DONE;
					last <= 1'b1; out_byte <= '0; record_len <= '0;
					state_q <= lphr_pkg::S_IDLE;
				end
				lphr_pkg::S_CNT: state_q <= lphr_pkg::S_CNT2;
				lphr_pkg::S_CNT2: begin
					if (rdata_q != 8'd0 && 32'(guard_q) < lphr_pkg::RING_BYTES) begin
						h_q <= wrp((PW+9)'(h_q) + rdata_q + (PW+9)'(1)); cnt_q <= cnt_q + 1'b1;
						guard_q <= guard_q + 1'b1; state_q <= lphr_pkg::S_CNT;
					end else begin
						h_q <= oldest_q; j_q <= '0; guard_q <= '0;
						if (older_q && cnt_q >= depth_q) state_q <= lphr_pkg::S_FND;
						else if (!older_q && depth_q != 7'd0) begin
							depth_q <= depth_q - 1'b1; state_q <= lphr_pkg::S_FND;
						end else begin
							strobe <= 1'b1; last <= 1'b1; out_byte <= '0; record_len <= '0;
							status <= older_q ? lphr_pkg::ST_NO_OLDER : lphr_pkg::ST_EMPTY;
							state_q <= lphr_pkg::S_IDLE;
						end
					end
				end
				lphr_pkg::S_FND: state_q <= lphr_pkg::S_FND2;
				lphr_pkg::S_FND2: begin
					if (rdata_q != 8'd0 && 32'(guard_q) < lphr_pkg::RING_BYTES &&
							(older_q ? (cnt_q - j_q - 7'd1 != depth_q) : (cnt_q - j_q != depth_q))) begin
						h_q <= wrp((PW+9)'(h_q) + rdata_q + (PW+9)'(1)); j_q <= j_q + 1'b1;
						guard_q <= guard_q + 1'b1; state_q <= lphr_pkg::S_FND;
					end else if (rdata_q != 8'd0) begin
						if (older_q) depth_q <= depth_q + 1'b1;
						len_q <= (rdata_q > 8'(lphr_pkg::LINE_BYTES)) ?
							7'(lphr_pkg::LINE_BYTES) : rdata_q[6:0];
						k_q <= '0; state_q <= lphr_pkg::S_EMB;
					end else begin
						strobe <= 1'b1; last <= 1'b1; out_byte <= '0; record_len <= '0;
						status <= older_q ? lphr_pkg::ST_NO_OLDER : lphr_pkg::ST_EMPTY;
						state_q <= lphr_pkg::S_IDLE;
					end
				end
				lphr_pkg::S_EMB: state_q <= lphr_pkg::S_EMB2;
				lphr_pkg::S_EMB2: begin
					strobe <= 1'b1; status <= lphr_pkg::ST_BYTE; out_byte <= rdata_q;
					record_len <= len_q; last <= (k_q + 1'b1 == len_q);
					k_q <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 == len_q) ? lphr_pkg::S_IDLE : lphr_pkg::S_EMB;
				end
				default: state_q <= lphr_pkg::S_IDLE;
			endcase
		end
	end

	a_save_bound: assert property (@(posedge clk) disable iff (!arst_n)
		save_q <= 7'(lphr_pkg::LINE_BYTES)) else $error("save count overrun");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> state_q == lphr_pkg::S_IDLE) else $error("last while busy");
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == lphr_pkg::ST_BYTE |-> record_len != 7'd0)
		else $error("byte with zero length");
endmodule
